>>> design/szc_pkg.sv
package szc_pkg;

	localparam int ZONE_SLOTS_DEF = 64;
	localparam int WINDOW_SLOTS_DEF = 32;

	localparam logic [2:0] OP_INSERT = 3'd0;
	localparam logic [2:0] OP_WRITE_WIN = 3'd1;
	localparam logic [2:0] OP_RESOLVE = 3'd2;
	localparam logic [2:0] OP_READ_ZONE = 3'd3;
	localparam logic [2:0] OP_CLEAR = 3'd4;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_OFF_SCREEN = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic [1:0] REG_SCREEN_W = 2'd0;
	localparam logic [1:0] REG_SCREEN_H = 2'd1;
	localparam logic [1:0] REG_WIN_COUNT = 2'd2;

	typedef struct packed {
		logic [2:0] opcode;
		logic [5:0] slot;
		logic signed [15:0] rect_x;
		logic signed [15:0] rect_y;
		logic [14:0] rect_width;
		logic [14:0] rect_height;
		logic visible;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic signed [15:0] zone_x;
		logic signed [15:0] zone_y;
		logic [14:0] zone_width;
		logic [14:0] zone_height;
		logic [5:0] zone_owner;
		logic [6:0] zone_total;
	} res_t;

	typedef struct packed {
		logic [5:0] owner;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [14:0] w;
		logic [14:0] h;
	} zone_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [14:0] w;
		logic [14:0] h;
	} win_t;

	typedef struct packed {
		logic signed [17:0] x;
		logic signed [17:0] y;
		logic signed [17:0] w;
		logic signed [17:0] h;
	} cand_t;

	typedef struct packed {
		logic off;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [14:0] w;
		logic [14:0] h;
	} clip_t;

endpackage

>>> design/szc_ram.sv
module szc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> design/szc_clip.sv
module szc_clip (
	input szc_pkg::cand_t cand,
	input logic [14:0] screen_width,
	input logic [14:0] screen_height,
	output szc_pkg::clip_t clip
);

	logic signed [17:0] sw, sh;
	logic signed [17:0] x1, w1, w2, y1, h1, h2;

	always_comb begin
		sw = signed'({3'b000, screen_width});
		sh = signed'({3'b000, screen_height});
		clip.off = (cand.x >= sw) || (cand.y >= sh) ||
			(cand.x + cand.w <= 18'sd0) || (cand.y + cand.h <= 18'sd0);
		if (cand.x < 18'sd0) begin
			w1 = cand.w + cand.x;
			x1 = 18'sd0;
		end else begin
			w1 = cand.w;
			x1 = cand.x;
		end
		w2 = (x1 + w1 > sw) ? sw - x1 : w1;
		if (w2 < 18'sd0) begin
			w2 = 18'sd0;
		end
		if (cand.y < 18'sd0) begin
			h1 = cand.h + cand.y;
			y1 = 18'sd0;
		end else begin
			h1 = cand.h;
			y1 = cand.y;
		end
		h2 = (y1 + h1 > sh) ? sh - y1 : h1;
		if (h2 < 18'sd0) begin
			h2 = 18'sd0;
		end
		clip.x = x1[15:0];
		clip.y = y1[15:0];
		clip.w = w2[14:0];
		clip.h = h2[14:0];
	end

endmodule

>>> design/screen_zone_clip_and_assign.sv
// Zone table with screen clipping and window assignment.
// Commands enter on cmd and are accepted when start is high and busy is low.
// Each command produces exactly one transaction on result, marked by a
// one-cycle done strobe; the receiver cannot stall it.
// Insert clips the rectangle against the screen registers and appends it as
// an unowned zone. Write window stores a window rectangle and its visible
// flag. Read zone returns one table entry. Clear empties the table.
// Resolve intersects every unowned zone with every visible window below the
// window count and appends each overlap tagged with the window slot plus one.
// Resolve is paced by the single zone and window memory read ports and the
// shared clip unit: it loads each zone in turn, skips hidden windows and
// tests each visible window for overlap.
// Configuration uses the APB port at byte addresses 0, 4 and 8.
// Reset empties the zone table, hides all windows and restores the screen
// size to 1024 by 768 with a window count of zero.
module screen_zone_clip_and_assign #(
	parameter int ZONE_SLOTS = szc_pkg::ZONE_SLOTS_DEF,
	parameter int WINDOW_SLOTS = szc_pkg::WINDOW_SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input szc_pkg::cmd_t cmd,
	output logic done,
	output szc_pkg::res_t result,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	localparam int ZW = $clog2(ZONE_SLOTS);
	localparam int FW = $clog2(ZONE_SLOTS + 1);
	localparam int WW = WINDOW_SLOTS > 1 ? $clog2(WINDOW_SLOTS) : 1;
	localparam int LW = $clog2(WINDOW_SLOTS + 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_PUT = 4'd1;
	localparam logic [3:0] S_WWIN = 4'd2;
	localparam logic [3:0] S_RREQ = 4'd3;
	localparam logic [3:0] S_RRET = 4'd4;
	localparam logic [3:0] S_RZ = 4'd5;
	localparam logic [3:0] S_LZ = 4'd6;
	localparam logic [3:0] S_RW = 4'd7;
	localparam logic [3:0] S_CW = 4'd8;
	localparam logic [3:0] S_CLR = 4'd9;

	logic [3:0] state_q;
	logic [14:0] screen_w_q, screen_h_q;
	logic [5:0] win_count_q;
	logic [FW-1:0] fill_q, z_q, scan_end_q;
	logic [LW-1:0] l_q, wc;
	logic [WINDOW_SLOTS-1:0] shown_q;
	logic full_seen_q;
	logic done_q;
	szc_pkg::res_t res_q;
	szc_pkg::cmd_t cmd_q;
	szc_pkg::zone_t zcur_q;
	szc_pkg::cand_t cand_q;
	logic [5:0] owner_q;

	logic zone_we;
	logic [ZW-1:0] zone_raddr;
	szc_pkg::zone_t zone_wdata, zone_rdata;
	logic win_we;
	szc_pkg::win_t win_wdata, win_rdata;
	szc_pkg::clip_t clip;
	logic full;
	logic accept;
	logic cfg_wr;

	logic signed [17:0] zx, zy, zr, zb, ox, oy, orr, ob, nx, ny, nr, nb;
	logic hit;

	assign accept = start && !busy;
	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign result = res_q;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign full = (32'(fill_q) >= ZONE_SLOTS);
	assign wc = (32'(win_count_q) > WINDOW_SLOTS) ? LW'(WINDOW_SLOTS) : LW'(win_count_q);

	always_comb begin
		case (paddr[3:2])
			szc_pkg::REG_SCREEN_W: prdata = {17'd0, screen_w_q};
			szc_pkg::REG_SCREEN_H: prdata = {17'd0, screen_h_q};
			szc_pkg::REG_WIN_COUNT: prdata = {26'd0, win_count_q};
			default: prdata = 32'd0;
		endcase
	end

	always_comb begin
		zx = 18'(zcur_q.x);
		zy = 18'(zcur_q.y);
		zr = zx + signed'({3'b000, zcur_q.w});
		zb = zy + signed'({3'b000, zcur_q.h});
		ox = 18'(win_rdata.x);
		oy = 18'(win_rdata.y);
		orr = ox + signed'({3'b000, win_rdata.w});
		ob = oy + signed'({3'b000, win_rdata.h});
		hit = !(orr <= zx || ob <= zy || ox >= zr || oy >= zb);
		nx = (zx < ox) ? ox : zx;
		ny = (zy < oy) ? oy : zy;
		nr = (zr > orr) ? orr : zr;
		nb = (zb > ob) ? ob : zb;
	end

	szc_clip u_clip (
		.cand(cand_q),
		.screen_width(screen_w_q),
		.screen_height(screen_h_q),
		.clip(clip)
	);

	assign zone_we = (state_q == S_PUT) && !clip.off && !full;
	assign zone_wdata = '{owner: owner_q, x: clip.x, y: clip.y, w: clip.w, h: clip.h};
	assign zone_raddr = (state_q == S_RREQ) ? ZW'(cmd_q.slot) : ZW'(z_q);

	szc_ram #(.WIDTH($bits(szc_pkg::zone_t)), .DEPTH(ZONE_SLOTS)) u_zone_ram (
		.clk(clk),
		.we(zone_we),
		.waddr(ZW'(fill_q)),
		.wdata(zone_wdata),
		.raddr(zone_raddr),
		.rdata(zone_rdata)
	);

	assign win_we = (state_q == S_WWIN) && (32'(cmd_q.slot) < WINDOW_SLOTS);
	assign win_wdata = '{x: cmd_q.rect_x, y: cmd_q.rect_y, w: cmd_q.rect_width,
		h: cmd_q.rect_height};

	szc_ram #(.WIDTH($bits(szc_pkg::win_t)), .DEPTH(WINDOW_SLOTS)) u_win_ram (
		.clk(clk),
		.we(win_we),
		.waddr(WW'(cmd_q.slot)),
		.wdata(win_wdata),
		.raddr(WW'(l_q)),
		.rdata(win_rdata)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			cand_q <= '{x: 18'(cmd.rect_x), y: 18'(cmd.rect_y),
				w: signed'({3'b000, cmd.rect_width}), h: signed'({3'b000, cmd.rect_height})};
			owner_q <= 6'd0;
		end else if (state_q == S_CW) begin
			cand_q <= '{x: nx, y: ny, w: nr - nx, h: nb - ny};
			owner_q <= 6'(l_q + LW'(1));
		end
		if (state_q == S_LZ) begin
			zcur_q <= zone_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			screen_w_q <= 15'd1024;
			screen_h_q <= 15'd768;
			win_count_q <= 6'd0;
			fill_q <= '0;
			z_q <= '0;
			scan_end_q <= '0;
			l_q <= '0;
			shown_q <= '0;
			full_seen_q <= 1'b0;
			done_q <= 1'b0;
			res_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_wr) begin
				case (paddr[3:2])
					szc_pkg::REG_SCREEN_W: screen_w_q <= pwdata[14:0];
					szc_pkg::REG_SCREEN_H: screen_h_q <= pwdata[14:0];
					szc_pkg::REG_WIN_COUNT: win_count_q <= pwdata[5:0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_q <= '0;
						case (cmd.opcode)
							szc_pkg::OP_INSERT: state_q <= S_PUT;
							szc_pkg::OP_WRITE_WIN: state_q <= S_WWIN;
							szc_pkg::OP_RESOLVE: begin
								z_q <= '0;
								scan_end_q <= fill_q;
								full_seen_q <= 1'b0;
								state_q <= S_RZ;
							end
							szc_pkg::OP_READ_ZONE: state_q <= S_RREQ;
							default: state_q <= S_CLR;
						endcase
					end
				end
				S_PUT: begin
					if (zone_we) begin
						fill_q <= fill_q + FW'(1);
					end
					if (cmd_q.opcode == szc_pkg::OP_INSERT) begin
						res_q.status <= clip.off ? szc_pkg::ST_OFF_SCREEN :
							(full ? szc_pkg::ST_FULL : szc_pkg::ST_OK);
						res_q.zone_total <= 7'(zone_we ? fill_q + FW'(1) : fill_q);
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						if (!clip.off && full) begin
							full_seen_q <= 1'b1;
						end
						l_q <= l_q + LW'(1);
						state_q <= S_RW;
					end
				end
				S_WWIN: begin
					if (32'(cmd_q.slot) < WINDOW_SLOTS) begin
						shown_q[WW'(cmd_q.slot)] <= cmd_q.visible;
					end
					res_q.zone_total <= 7'(fill_q);
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_RREQ: state_q <= S_RRET;
				S_RRET: begin
					if (32'(cmd_q.slot) < 32'(fill_q)) begin
						res_q.zone_x <= zone_rdata.x;
						res_q.zone_y <= zone_rdata.y;
						res_q.zone_width <= zone_rdata.w;
						res_q.zone_height <= zone_rdata.h;
						res_q.zone_owner <= zone_rdata.owner;
					end
					res_q.zone_total <= 7'(fill_q);
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_RZ: begin
					if (z_q >= scan_end_q) begin
						res_q.status <= full_seen_q ? szc_pkg::ST_FULL : szc_pkg::ST_OK;
						res_q.zone_total <= 7'(fill_q);
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_LZ;
					end
				end
				S_LZ: begin
					if (zone_rdata.owner != 6'd0) begin
						z_q <= z_q + FW'(1);
						state_q <= S_RZ;
					end else begin
						l_q <= '0;
						state_q <= S_RW;
					end
				end
				S_RW: begin
					if (l_q >= wc) begin
						z_q <= z_q + FW'(1);
						state_q <= S_RZ;
					end else if (!shown_q[WW'(l_q)]) begin
						l_q <= l_q + LW'(1);
					end else begin
						state_q <= S_CW;
					end
				end
				S_CW: begin
					if (hit) begin
						state_q <= S_PUT;
					end else begin
						l_q <= l_q + LW'(1);
						state_q <= S_RW;
					end
				end
				S_CLR: begin
					if (cmd_q.opcode == szc_pkg::OP_CLEAR) begin
						fill_q <= '0;
						res_q.zone_total <= 7'd0;
					end else begin
						res_q.zone_total <= 7'(fill_q);
					end
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done strobe while busy");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= ZONE_SLOTS) else $error("zone fill exceeds table");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy) else $error("accepted command did not start");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status == szc_pkg::ST_OK ||
			result.status == szc_pkg::ST_OFF_SCREEN ||
			result.status == szc_pkg::ST_FULL)) else $error("bad status code");
`endif

endmodule
